// ===== src/cfc_pkg.sv =====
`default_nettype none

package cfc_pkg;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam logic [31:0] FRAME_MAGIC_RESET = 32'h0000_0000;
    localparam logic [15:0] LEN_LIMIT_RESET   = 16'd1024;

    // Configuration register indexes
    localparam logic CFG_FRAME_MAGIC = 1'b0;
    localparam logic CFG_LEN_LIMIT   = 1'b1;

    // Frame status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_MAGIC = 2'd1;
    localparam logic [1:0] STATUS_BAD_LEN   = 2'd2;
    localparam logic [1:0] STATUS_BAD_CRC   = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_MAGIC   = 3'd1,
        PH_LEN     = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CRC     = 3'd4,
        PH_DROP    = 3'd5
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } in_item_t;

    typedef struct packed {
        logic       is_status;
        logic [7:0] payload_byte;
        logic [1:0] frame_status;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic [31:0] frame_magic;
        logic [15:0] len_limit;
    } cfg_t;

    typedef struct packed {
        logic      valid;
        out_item_t item;
    } result_t;

endpackage

`default_nettype wire

// ===== src/cfc_crc_update.sv =====
`default_nettype none

module cfc_crc_update (
    input  wire logic [31:0] crc_in,
    input  wire logic [7:0]  data_in,
    output logic      [31:0] crc_out
);

    logic [31:0] c;

    // Eight reflected bit steps, flattened into one XOR network
    always_comb begin
        c = crc_in ^ {24'd0, data_in};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ cfc_pkg::CRC_POLY) : (c >> 1);
        end
        crc_out = c;
    end

endmodule

`default_nettype wire

// ===== src/cfc_frame_fsm.sv =====
`default_nettype none

module cfc_frame_fsm #(
    parameter int PAYLOAD_LIMIT = 65535
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             step,
    input  wire cfc_pkg::in_item_t in_item,
    input  wire cfc_pkg::cfg_t     cfg,
    output cfc_pkg::result_t       result
);

    localparam int CNT_W = $clog2(PAYLOAD_LIMIT + 1);
    localparam logic [31:0] LIMIT_32 = 32'(PAYLOAD_LIMIT);

    cfc_pkg::phase_t phase_reg, phase_next, eff_phase;
    logic [1:0]       wcnt_reg, wcnt_next, eff_wcnt;
    logic [CNT_W-1:0] pcnt_reg, pcnt_next, eff_pcnt, pcnt_inc;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [31:0]      word_reg, word_next, eff_word, word_new;
    logic [31:0]      crc_reg, crc_next, eff_crc, crc_new;
    logic [31:0]      limit;
    logic             word_done;
    logic             magic_ok;
    logic             len_bad;

    // A start marker restarts the frame with this very byte
    assign eff_phase = in_item.frame_start ? cfc_pkg::PH_MAGIC : phase_reg;
    assign eff_wcnt  = in_item.frame_start ? 2'd0 : wcnt_reg;
    assign eff_pcnt  = in_item.frame_start ? '0 : pcnt_reg;
    assign eff_word  = in_item.frame_start ? 32'd0 : word_reg;
    assign eff_crc   = in_item.frame_start ? cfc_pkg::CRC_INIT : crc_reg;

    assign word_new  = {in_item.data_byte, eff_word[31:8]};
    assign word_done = (eff_wcnt == 2'd3);
    assign pcnt_inc  = eff_pcnt + 1'b1;
    assign magic_ok  = (word_new == cfg.frame_magic);
    assign limit     = ({16'd0, cfg.len_limit} > LIMIT_32) ? LIMIT_32
                                                          : {16'd0, cfg.len_limit};
    assign len_bad   = (word_new > limit);

    cfc_crc_update u_crc (
        .crc_in  (eff_crc),
        .data_in (in_item.data_byte),
        .crc_out (crc_new)
    );

    // Next state and datapath
    always_comb begin
        phase_next = phase_reg;
        wcnt_next  = wcnt_reg;
        pcnt_next  = pcnt_reg;
        len_next   = len_reg;
        word_next  = word_reg;
        crc_next   = crc_reg;
        if (step) begin
            phase_next = eff_phase;
            wcnt_next  = eff_wcnt;
            pcnt_next  = eff_pcnt;
            word_next  = eff_word;
            crc_next   = eff_crc;
            unique case (eff_phase)
                cfc_pkg::PH_MAGIC, cfc_pkg::PH_LEN, cfc_pkg::PH_CRC: begin
                    word_next = word_new;
                    wcnt_next = eff_wcnt + 2'd1;
                    if (word_done) begin
                        priority if (eff_phase == cfc_pkg::PH_MAGIC) begin
                            phase_next = magic_ok ? cfc_pkg::PH_LEN : cfc_pkg::PH_DROP;
                        end else if (eff_phase == cfc_pkg::PH_LEN) begin
                            len_next = word_new[CNT_W-1:0];
                            if (len_bad) begin
                                phase_next = cfc_pkg::PH_DROP;
                            end else if (word_new == 32'd0) begin
                                phase_next = cfc_pkg::PH_CRC;
                            end else begin
                                phase_next = cfc_pkg::PH_PAYLOAD;
                            end
                        end else begin
                            phase_next = cfc_pkg::PH_IDLE;
                        end
                    end
                end
                cfc_pkg::PH_PAYLOAD: begin
                    crc_next  = crc_new;
                    pcnt_next = pcnt_inc;
                    if (pcnt_inc >= len_reg) begin
                        pcnt_next  = '0;
                        wcnt_next  = 2'd0;
                        word_next  = 32'd0;
                        phase_next = cfc_pkg::PH_CRC;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Results
    always_comb begin
        result.valid             = 1'b0;
        result.item.is_status    = 1'b0;
        result.item.payload_byte = 8'd0;
        result.item.frame_status = cfc_pkg::STATUS_OK;
        result.item.last         = 1'b0;
        if (step) begin
            unique case (eff_phase)
                cfc_pkg::PH_MAGIC: begin
                    if (word_done && !magic_ok) begin
                        result.valid             = 1'b1;
                        result.item.is_status    = 1'b1;
                        result.item.frame_status = cfc_pkg::STATUS_BAD_MAGIC;
                        result.item.last         = 1'b1;
                    end
                end
                cfc_pkg::PH_LEN: begin
                    if (word_done && len_bad) begin
                        result.valid             = 1'b1;
                        result.item.is_status    = 1'b1;
                        result.item.frame_status = cfc_pkg::STATUS_BAD_LEN;
                        result.item.last         = 1'b1;
                    end
                end
                cfc_pkg::PH_CRC: begin
                    if (word_done) begin
                        result.valid             = 1'b1;
                        result.item.is_status    = 1'b1;
                        result.item.frame_status = (word_new == ~eff_crc)
                                                   ? cfc_pkg::STATUS_OK
                                                   : cfc_pkg::STATUS_BAD_CRC;
                        result.item.last         = 1'b1;
                    end
                end
                cfc_pkg::PH_PAYLOAD: begin
                    result.valid             = 1'b1;
                    result.item.payload_byte = in_item.data_byte;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= cfc_pkg::PH_IDLE;
            wcnt_reg  <= 2'd0;
            pcnt_reg  <= '0;
            len_reg   <= '0;
            word_reg  <= 32'd0;
            crc_reg   <= cfc_pkg::CRC_INIT;
        end else begin
            phase_reg <= phase_next;
            wcnt_reg  <= wcnt_next;
            pcnt_reg  <= pcnt_next;
            len_reg   <= len_next;
            word_reg  <= word_next;
            crc_reg   <= crc_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/cfc_out_stage.sv =====
`default_nettype none

module cfc_out_stage (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cfc_pkg::result_t  push,
    output logic                   can_take,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output cfc_pkg::out_item_t     m_item
);

    logic               valid_reg;
    cfc_pkg::out_item_t item_reg;

    // Free when empty or when the held item leaves this cycle
    assign can_take = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_item   = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (can_take) begin
            valid_reg <= push.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (can_take && push.valid) begin
            item_reg <= push.item;
        end
    end

endmodule

`default_nettype wire

// ===== src/crc32_frame_checker_core.sv =====
// Length-prefixed frame checker with CRC-32.
// Input channel (s_valid/s_ready/s_item): one stream byte per item; frame_start
// marks the first magic byte of a frame and abandons any frame in progress.
// Frame layout: 4-byte magic, 4-byte length, payload, 4-byte CRC-32 over the
// payload, all little-endian.
// Result channel (m_valid/m_ready/m_item): one item per payload byte
// (is_status = 0), and one status item with last = 1 at frame end: ok, bad
// magic, bad length (above min(len_limit, PAYLOAD_LIMIT)) or CRC error.
// Bytes while idle or after an early error produce no item.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 frame_magic,
// index 1 len_limit; always ready, write only while idle.
// Throughput: one byte per cycle unless stalled. Latency: a result appears on
// m_valid the cycle after its byte is accepted; the byte-wide CRC update and
// the frame parser settle between the parser state and the output register.
// Reset (aresetn low, synchronous) goes idle, empties the output register and
// loads frame_magic = 0, len_limit = 1024.
// A stalled receiver holds its item; s_ready drops until m_ready returns.
`default_nettype none

module crc32_frame_checker_core #(
    parameter int PAYLOAD_LIMIT = 65535
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire cfc_pkg::in_item_t  s_item,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output cfc_pkg::out_item_t      m_item,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_index,
    input  wire logic [31:0]        cfg_data
);

    cfc_pkg::cfg_t    cfg_reg;
    cfc_pkg::result_t result;
    logic             can_take;
    logic             step;

    assign cfg_ready = 1'b1;
    assign s_ready   = can_take;
    assign step      = s_valid && can_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_magic <= cfc_pkg::FRAME_MAGIC_RESET;
            cfg_reg.len_limit   <= cfc_pkg::LEN_LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                cfc_pkg::CFG_FRAME_MAGIC: cfg_reg.frame_magic <= cfg_data;
                cfc_pkg::CFG_LEN_LIMIT:   cfg_reg.len_limit   <= cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    cfc_frame_fsm #(
        .PAYLOAD_LIMIT (PAYLOAD_LIMIT)
    ) u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .in_item (s_item),
        .cfg     (cfg_reg),
        .result  (result)
    );

    cfc_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (result),
        .can_take (can_take),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule

`default_nettype wire

// ===== src/cfc_checker.sv =====
`default_nettype none

module cfc_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire cfc_pkg::out_item_t m_item
);

    // Held result stays put while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result item changed while stalled");

    // A stalled full output register must block new bytes
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input accepted while output is stalled");

    // Status items close a frame; byte items carry no status
    a_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.is_status == m_item.last)
                 && (m_item.is_status || m_item.frame_status == cfc_pkg::STATUS_OK))
        else $error("inconsistent result item fields");

    // Nothing comes out right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind crc32_frame_checker_core cfc_checker u_cfc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

`default_nettype wire
